// File: rtl/lbp_pkg.sv
package lbp_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 1'd1;

  localparam int PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2000;

  // Quarter of the period, and its largest value
  localparam int QUARTER_W = PERIOD_W - 2;
  localparam int QUARTER_MAX = (1 << QUARTER_W) - 1;

  localparam int DUTY_W  = 5;
  localparam int PHASE_W = 2;

  // Breathing phases
  localparam logic [PHASE_W-1:0] PH_RAMP_UP   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HOLD_ON   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RAMP_DOWN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_HOLD_OFF  = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_STEP
  } seq_state_t;

endpackage

// File: rtl/lbp_if.sv
interface lbp_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface lbp_led_if;
  logic       valid;
  logic       ready;
  logic       pin_level;
  logic [4:0] duty_ms;
  logic [1:0] phase;
  logic       cycle_done;

  modport source (output valid, output pin_level, output duty_ms, output phase,
                  output cycle_done, input ready);
  modport sink   (input valid, input pin_level, input duty_ms, input phase,
                  input cycle_done, output ready);
endinterface

// File: rtl/lbp_step_search.sv
// Step length search: one add and one compare per cycle. Finds the smallest
// j >= 1 with quarter <= j * FRAME_MS * FRAME_MS, and the last frame index
// FRAME_MS * j - 1, by accumulating both products step by step.
module lbp_step_search
  import lbp_pkg::*;
#(
  parameter int FRAME_MS = 20,
  parameter int STEP_W   = 6,
  parameter int FIDX_W   = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [QUARTER_W-1:0] quarter,
  output logic                 done,
  output logic [STEP_W-1:0]    step_length,
  output logic [FIDX_W-1:0]    last_frame
);

  localparam int SQ    = FRAME_MS * FRAME_MS;
  localparam int ACC_W = $clog2(QUARTER_MAX + SQ + 1);

  localparam logic [ACC_W-1:0]  SQ_C    = ACC_W'(SQ);
  localparam logic [FIDX_W-1:0] FRAME_C = FIDX_W'(FRAME_MS);

  logic                 busy;
  logic [STEP_W-1:0]    j;
  logic [ACC_W-1:0]     acc;
  logic [FIDX_W-1:0]    frames;
  logic [QUARTER_W-1:0] target;
  logic                 reached;

  assign reached = (acc >= ACC_W'(target));

  // Control: busy until the accumulated product covers the quarter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && reached) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: advance j and both running products
  always_ff @(posedge clk) begin
    if (start) begin
      target <= quarter;
      j      <= STEP_W'(1);
      acc    <= SQ_C;
      frames <= FRAME_C;
    end else if (busy) begin
      if (reached) begin
        step_length <= j;
        last_frame  <= frames - FIDX_W'(1);
      end else begin
        j      <= j + STEP_W'(1);
        acc    <= acc + SQ_C;
        frames <= frames + FRAME_C;
      end
    end
  end

endmodule

// File: rtl/led_breathing_pwm_core.sv
// Breathing-LED PWM sequencer.
// Channels: tick_ch (sink) carries one beat per millisecond slot; tick = 1
// means one millisecond passes, tick = 0 only samples the coming millisecond.
// led_ch (source) returns exactly one beat per input beat: pin level, duty,
// phase and an end-of-cycle mark. cfg_we/cfg_idx/cfg_data write period_ms
// (index 0) and active_level (index 1); write only while the block is idle.
// Handshake: tick_ch.ready is high only in the idle state. An ordinary
// beat moves the sequencer to the step state, which writes the result
// register and returns to idle, so a beat is taken only after the last
// one is through. The first tick of a breathing cycle first runs the step
// length search in its own adder and comparator, trying j up to
// JMAX = ceil(16383 / FRAME_MS^2) (41 at FRAME_MS = 20).
// A result waits in the output register while led_ch.ready is low; the
// next beat is still accepted and is held until the register frees.
// Reset: ramp-up phase, duty 0, period 2000 ms, active level 0; the next
// tick starts a fresh cycle. Results in flight are dropped.
module led_breathing_pwm_core
  import lbp_pkg::*;
#(
  parameter int FRAME_MS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  lbp_tick_if.sink              tick_ch,
  lbp_led_if.source             led_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SQ     = FRAME_MS * FRAME_MS;
  localparam int JMAX   = (QUARTER_MAX + SQ - 1) / SQ;
  localparam int STEP_W = $clog2(JMAX + 1);
  localparam int FIDX_W = $clog2(FRAME_MS * JMAX + 1);

  localparam logic [DUTY_W-1:0] FRAME_C = DUTY_W'(FRAME_MS);

  // Configuration
  logic [PERIOD_W-1:0] period_ms;
  logic                active_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms    <= PERIOD_RESET;
      active_level <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_PERIOD_MS) period_ms <= cfg_data[PERIOD_W-1:0];
      if (cfg_idx == REG_ACTIVE_LEVEL) active_level <= cfg_data[0];
    end
  end

  // Sequencer
  seq_state_t state, state_next;
  logic in_accept, search_start, search_done, step_fire, tick_r;
  logic at_start;

  assign in_accept = tick_ch.valid && tick_ch.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_accept) state_next = search_start ? S_SEARCH : S_STEP;
      S_SEARCH: if (search_done) state_next = S_STEP;
      S_STEP:   if (step_fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tick_ch.ready = (state == S_IDLE);
    search_start  = in_accept && tick_ch.tick && at_start;
    step_fire     = (state == S_STEP) && (!led_ch.valid || led_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (in_accept) tick_r <= tick_ch.tick;
  end

  // Breathing state
  logic [PHASE_W-1:0]   phase_reg, phase_reg_next;
  logic [FIDX_W-1:0]    frame_index, frame_index_next;
  logic [DUTY_W-1:0]    duty_reg, duty_reg_next;
  logic [DUTY_W-1:0]    frame_ms_count, frame_ms_count_next;
  logic [QUARTER_W-1:0] hold_count, hold_count_next;
  logic [STEP_W-1:0]    step_count, step_count_next;
  logic [QUARTER_W-1:0] quarter_len;
  logic [STEP_W-1:0]    step_length;
  logic [FIDX_W-1:0]    last_frame;
  logic                 at_start_next;

  lbp_step_search #(
    .FRAME_MS (FRAME_MS),
    .STEP_W   (STEP_W),
    .FIDX_W   (FIDX_W)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .start       (search_start),
    .quarter     (period_ms[PERIOD_W-1:2]),
    .done        (search_done),
    .step_length (step_length),
    .last_frame  (last_frame)
  );

  // Result and next state of one millisecond
  logic                 pin_on, pin, done;
  logic [PHASE_W-1:0]   ph;
  logic [DUTY_W-1:0]    duty;
  logic [DUTY_W-1:0]    off_len, cnt_inc;
  logic [STEP_W-1:0]    step_inc;
  logic [QUARTER_W-1:0] hold_inc;

  always_comb begin
    off_len  = FRAME_C - duty_reg;
    cnt_inc  = frame_ms_count + DUTY_W'(1);
    step_inc = step_count + STEP_W'(1);
    hold_inc = hold_count + QUARTER_W'(1);

    case (phase_reg)
      PH_RAMP_UP:   pin_on = (frame_ms_count >= off_len);
      PH_HOLD_ON:   pin_on = 1'b1;
      PH_RAMP_DOWN: pin_on = (frame_ms_count < off_len);
      default:      pin_on = 1'b0;
    endcase
    if (at_start) pin_on = 1'b0;
    pin  = pin_on ? active_level : ~active_level;
    ph   = at_start ? PH_RAMP_UP : phase_reg;
    duty = (at_start || ph == PH_HOLD_ON || ph == PH_HOLD_OFF) ? '0 : duty_reg;

    phase_reg_next      = phase_reg;
    frame_index_next    = frame_index;
    duty_reg_next       = duty_reg;
    frame_ms_count_next = frame_ms_count;
    hold_count_next     = hold_count;
    step_count_next     = step_count;
    at_start_next       = at_start;
    done                = 1'b0;

    if (tick_r) begin
      if (phase_reg == PH_RAMP_UP || phase_reg == PH_RAMP_DOWN) begin
        frame_ms_count_next = cnt_inc;
        if (cnt_inc >= FRAME_C) begin
          frame_ms_count_next = '0;
          if (frame_index >= last_frame) begin
            // End of ramp: hold, or skip the hold when the quarter is zero
            hold_count_next  = '0;
            frame_index_next = FIDX_W'(1);
            duty_reg_next    = '0;
            step_count_next  = '0;
            if (phase_reg == PH_RAMP_UP) begin
              phase_reg_next = (quarter_len == '0) ? PH_RAMP_DOWN : PH_HOLD_ON;
            end else if (quarter_len == '0) begin
              phase_reg_next = PH_RAMP_UP;
              done           = 1'b1;
              at_start_next  = 1'b1;
            end else begin
              phase_reg_next = PH_HOLD_OFF;
            end
          end else begin
            frame_index_next = frame_index + FIDX_W'(1);
            step_count_next  = step_inc;
            if (step_inc >= step_length) begin
              step_count_next = '0;
              duty_reg_next   = duty_reg + DUTY_W'(1);
            end
          end
        end
      end else begin
        hold_count_next = hold_inc;
        if (hold_inc >= quarter_len) begin
          hold_count_next     = '0;
          frame_index_next    = FIDX_W'(1);
          duty_reg_next       = '0;
          frame_ms_count_next = '0;
          step_count_next     = '0;
          if (phase_reg == PH_HOLD_ON) begin
            phase_reg_next = PH_RAMP_DOWN;
          end else begin
            phase_reg_next = PH_RAMP_UP;
            done           = 1'b1;
            at_start_next  = 1'b1;
          end
        end
      end
    end
  end

  // Commit the millisecond step
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start       <= 1'b1;
      phase_reg      <= PH_RAMP_UP;
      frame_index    <= FIDX_W'(1);
      duty_reg       <= '0;
      frame_ms_count <= '0;
      hold_count     <= '0;
      step_count     <= '0;
    end else if (search_start) begin
      at_start <= 1'b0;
    end else if (step_fire) begin
      at_start       <= at_start_next;
      phase_reg      <= phase_reg_next;
      frame_index    <= frame_index_next;
      duty_reg       <= duty_reg_next;
      frame_ms_count <= frame_ms_count_next;
      hold_count     <= hold_count_next;
      step_count     <= step_count_next;
    end
  end

  // Latch the quarter at cycle start
  always_ff @(posedge clk) begin
    if (search_start) quarter_len <= period_ms[PERIOD_W-1:2];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      led_ch.valid <= 1'b0;
    end else if (step_fire) begin
      led_ch.valid <= 1'b1;
    end else if (led_ch.ready) begin
      led_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      led_ch.pin_level  <= pin;
      led_ch.duty_ms    <= duty;
      led_ch.phase      <= ph;
      led_ch.cycle_done <= done;
    end
  end

endmodule

// File: rtl/lbp_checker.sv
module lbp_checker
  import lbp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DUTY_W-1:0]  duty_ms,
  input logic [PHASE_W-1:0] phase,
  input logic               cycle_done
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Drop ready in the cycle after each accepted tick beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("tick beat accepted back to back");

  // Hold phases report zero duty
  a_hold_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == PH_HOLD_ON || phase == PH_HOLD_OFF) |-> duty_ms == '0)
    else $error("non-zero duty in a hold phase");

  // A cycle ends only in ramp down or hold off
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && cycle_done |-> (phase == PH_RAMP_DOWN || phase == PH_HOLD_OFF))
    else $error("cycle end outside the falling half");

endmodule

bind led_breathing_pwm_core lbp_checker u_lbp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (tick_ch.valid),
  .in_ready   (tick_ch.ready),
  .out_valid  (led_ch.valid),
  .out_ready  (led_ch.ready),
  .duty_ms    (led_ch.duty_ms),
  .phase      (led_ch.phase),
  .cycle_done (led_ch.cycle_done)
);
